// ===== rtl/pvp_pkg.sv =====
// Shared types, constants and helpers for the path velocity profile block.
package pvp_pkg;

  localparam int PVP_MAX_POINTS = 64;
  localparam int PVP_JOINTS     = 3;
  localparam int MAX_JOINTS     = 3;

  localparam int REG_W  = 31;
  localparam int CFG_AW = 3;
  localparam int DATA_W = 32;
  localparam int SQ_W   = 46;
  localparam int MAG_W  = 47;
  localparam int ACC_W  = 48;
  localparam int DIVN_W = 63;
  localparam int DIVD_W = 32;
  localparam int ROOT_W = 31;
  localparam int RAD_W  = 62;
  localparam int TIME_W = 32;
  localparam int IDX_W  = 6;
  localparam int IN_W   = 192;
  localparam int OUT_W  = 72;

  localparam logic [REG_W-1:0]        VMAX     = 31'h7FFF_FFFF;
  localparam logic [MAG_W-1:0]        WIDE_MAG = 47'h7FFF_FFFF_FFFF;
  localparam logic signed [ACC_W-1:0] WIDE     = 48'sh7FFF_FFFF_FFFF;
  localparam logic [SQ_W-1:0]         SQ_CAP   = 46'h3FFF_FFFF_FFFF;
  localparam logic [TIME_W-1:0]       TMAX     = 32'hFFFF_FFFF;

  localparam logic [REG_W-1:0] VEL_RST  = 31'd65536;
  localparam logic [REG_W-1:0] ACC_RST  = 31'd65536;
  localparam logic [REG_W-1:0] STEP_RST = 31'd1024;

  localparam logic [CFG_AW-1:0] REG_VEL_0 = 3'd0;
  localparam logic [CFG_AW-1:0] REG_VEL_1 = 3'd1;
  localparam logic [CFG_AW-1:0] REG_VEL_2 = 3'd2;
  localparam logic [CFG_AW-1:0] REG_ACC_0 = 3'd3;
  localparam logic [CFG_AW-1:0] REG_ACC_1 = 3'd4;
  localparam logic [CFG_AW-1:0] REG_ACC_2 = 3'd5;
  localparam logic [CFG_AW-1:0] REG_STEP  = 3'd6;

  typedef struct packed {
    logic            start;
    logic            acc_op;
    logic            upper;
    logic [SQ_W-1:0] sq;
  } lane_cmd_t;

  typedef struct packed {
    logic                    done;
    logic signed [ACC_W-1:0] value;
  } lane_res_t;

  typedef enum logic [2:0] {
    LN_IDLE, LN_READ, LN_TERM, LN_NUM, LN_DIV
  } lane_state_t;

  typedef enum logic [4:0] {
    ST_LOAD, ST_FWD_INIT, ST_REV_INIT, ST_SQ, ST_ACC, ST_ACCW, ST_CAP, ST_CAPW,
    ST_MUL, ST_INC, ST_ARG, ST_ROOT, ST_EMIT_INIT, ST_EMIT_RD, ST_EMIT_DAT,
    ST_EMIT_DIVW, ST_EMIT_OUT
  } pvp_state_t;

  function automatic logic [DATA_W-1:0] mag32(input logic [DATA_W-1:0] v);
    return v[DATA_W-1] ? (~v + 32'd1) : v;
  endfunction

endpackage

// ===== rtl/path_velocity_profile_top.sv =====
// Loading takes one item per cycle; after the final point the profile is computed.
// Forward pass per point: square, lane acceleration bound, lane speed cap, multiply,
// increment, argument, square root; the reverse pass skips the speed cap. Each later
// result waits on the time divider and on output stalls.
// Synchronous active-low reset returns to loading with an empty point store and
// default limits; the point and speed memories are not cleared.
module path_velocity_profile_top
  import pvp_pkg::*;
#(
  parameter int MAX_POINTS = PVP_MAX_POINTS,
  parameter int JOINTS     = PVP_JOINTS
)
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  // joint0_rate, joint0_curvature, joint1_rate, joint1_curvature,
  // joint2_rate, joint2_curvature
  input  logic [IN_W-1:0]   in_tdata,
  input  logic              in_tlast,
  output logic              out_tvalid,
  input  logic              out_tready,
  // point_index, path_speed, elapsed_time, zero pad
  output logic [OUT_W-1:0]  out_tdata,
  output logic              out_tlast,
  input  logic              cfg_wr_en,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [REG_W-1:0]  cfg_wdata
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);

  logic [REG_W-1:0] vel_lim_r [MAX_JOINTS];
  logic [REG_W-1:0] acc_lim_r [MAX_JOINTS];
  logic [REG_W-1:0] step_r;

  pvp_state_t              state_r, state_nxt;
  logic [CW-1:0]           count_r, count_nxt;
  logic [CW-1:0]           n_r, n_nxt;
  logic [AW-1:0]           idx_r, idx_nxt;
  logic                    rev_r, rev_nxt;
  logic [REG_W-1:0]        cur_v_r, cur_v_nxt;
  logic [SQ_W-1:0]         sq_r, sq_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic [REG_W-1:0]        cap_r, cap_nxt;
  logic [61:0]             phi_r, phi_nxt;
  logic [46:0]             plo_r, plo_nxt;
  logic signed [ACC_W:0]   inc_r, inc_nxt;
  logic [REG_W-1:0]        v_r, v_nxt;
  logic [REG_W-1:0]        prev_r, prev_nxt;
  logic [TIME_W-1:0]       t_r, t_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]        out_idx_r, out_idx_nxt;
  logic [REG_W-1:0]        out_speed_r, out_speed_nxt;
  logic [TIME_W-1:0]       out_time_r, out_time_nxt;
  logic                    out_last_r, out_last_nxt;

  logic [REG_W-1:0] fs_mem [MAX_POINTS];
  logic [REG_W-1:0] rs_mem [MAX_POINTS];
  logic [REG_W-1:0] fs_q;
  logic [REG_W-1:0] rs_q;
  logic             fs_we, rs_we;
  logic [AW-1:0]    fs_waddr, rs_waddr;
  logic [REG_W-1:0] fs_wdata, rs_wdata;

  logic              in_acc;
  logic              lane_we;
  lane_cmd_t         lane_cmd;
  logic [AW-1:0]     lane_addr;
  lane_res_t         lane_res [JOINTS];
  lane_res_t         mrg;
  logic              min_sel;
  logic              sq_start;
  logic [RAD_W-1:0]  sq_rad;
  logic              sq_done;
  logic [ROOT_W-1:0] sq_root;
  logic              div_start;
  logic [DIVN_W-1:0] div_num;
  logic [DIVD_W-1:0] div_den;
  logic              div_done;
  logic [DIVN_W-1:0] div_q;
  logic [2*REG_W-1:0] vsq;

  assign in_tready = (state_r == ST_LOAD);
  assign in_acc    = in_tvalid && in_tready;
  assign lane_we   = in_acc && (count_r < CW'(MAX_POINTS));
  assign vsq       = cur_v_r * cur_v_r;
  assign min_sel   = !(lane_cmd.acc_op && rev_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < MAX_JOINTS; j++) begin
        vel_lim_r[j] <= VEL_RST;
        acc_lim_r[j] <= ACC_RST;
      end
      step_r <= STEP_RST;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_VEL_0: vel_lim_r[0] <= cfg_wdata;
        REG_VEL_1: vel_lim_r[1] <= cfg_wdata;
        REG_VEL_2: vel_lim_r[2] <= cfg_wdata;
        REG_ACC_0: acc_lim_r[0] <= cfg_wdata;
        REG_ACC_1: acc_lim_r[1] <= cfg_wdata;
        REG_ACC_2: acc_lim_r[2] <= cfg_wdata;
        REG_STEP:  step_r       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (fs_we) begin
      fs_mem[fs_waddr] <= fs_wdata;
    end
    if (rs_we) begin
      rs_mem[rs_waddr] <= rs_wdata;
    end
    fs_q <= fs_mem[AW'(idx_r - 1'b1)];
    rs_q <= rs_mem[idx_r];
  end

  always_comb begin
    logic [MAG_W-1:0]      amag;
    logic [DIVN_W-1:0]     incq;
    logic [DIVN_W:0]       inc2;
    logic [MAG_W-1:0]      imag;
    logic signed [ACC_W:0] argw;
    logic [SQ_W-1:0]       arg;
    logic [REG_W-1:0]      lim;
    logic [REG_W-1:0]      nv;
    logic [DIVN_W:0]       tsum;
    logic [TIME_W-1:0]     tn;
    state_nxt     = state_r;
    count_nxt     = count_r;
    n_nxt         = n_r;
    idx_nxt       = idx_r;
    rev_nxt       = rev_r;
    cur_v_nxt     = cur_v_r;
    sq_nxt        = sq_r;
    acc_nxt       = acc_r;
    cap_nxt       = cap_r;
    phi_nxt       = phi_r;
    plo_nxt       = plo_r;
    inc_nxt       = inc_r;
    v_nxt         = v_r;
    prev_nxt      = prev_r;
    t_nxt         = t_r;
    out_valid_nxt = out_valid_r;
    out_idx_nxt   = out_idx_r;
    out_speed_nxt = out_speed_r;
    out_time_nxt  = out_time_r;
    out_last_nxt  = out_last_r;
    fs_we         = 1'b0;
    fs_waddr      = idx_r;
    fs_wdata      = '0;
    rs_we         = 1'b0;
    rs_waddr      = idx_r;
    rs_wdata      = '0;
    lane_cmd.start  = 1'b0;
    lane_cmd.acc_op = 1'b1;
    lane_cmd.upper  = !rev_r;
    lane_cmd.sq     = sq_r;
    lane_addr     = rev_r ? AW'(idx_r - 1'b1) : idx_r;
    sq_start      = 1'b0;
    div_start     = 1'b0;
    div_num       = {15'd0, step_r, 17'd0};
    div_den       = DIVD_W'(prev_r) + DIVD_W'(rs_q) + 32'd1;

    amag = acc_r[ACC_W-1] ? MAG_W'(-acc_r) : MAG_W'(acc_r);
    incq = {1'b0, phi_r} + DIVN_W'(plo_r[46:16]);
    inc2 = {incq, 1'b0};
    imag = (inc2 > (DIVN_W+1)'(WIDE_MAG)) ? WIDE_MAG : inc2[MAG_W-1:0];
    argw = $signed({3'd0, sq_r}) + inc_r;
    if (argw[ACC_W]) begin
      arg = '0;
    end else if (argw > $signed({3'd0, SQ_CAP})) begin
      arg = SQ_CAP;
    end else begin
      arg = argw[SQ_W-1:0];
    end
    sq_rad = {arg, 16'd0};
    lim    = rev_r ? fs_q : cap_r;
    nv     = (sq_root < lim) ? sq_root : lim;
    tsum   = (DIVN_W+1)'(t_r) + (DIVN_W+1)'(div_q);
    tn     = (tsum > (DIVN_W+1)'(TMAX)) ? TMAX : tsum[TIME_W-1:0];

    case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          if (count_r < CW'(MAX_POINTS)) begin
            count_nxt = count_r + 1'b1;
          end
          if (in_tlast) begin
            n_nxt     = (count_r < CW'(MAX_POINTS)) ? count_r + 1'b1 : count_r;
            state_nxt = ST_FWD_INIT;
          end
        end
      end
      ST_FWD_INIT: begin
        fs_we     = 1'b1;
        fs_waddr  = '0;
        idx_nxt   = '0;
        cur_v_nxt = '0;
        rev_nxt   = 1'b0;
        state_nxt = (n_r > CW'(1)) ? ST_SQ : ST_REV_INIT;
      end
      ST_REV_INIT: begin
        rs_we     = 1'b1;
        rs_waddr  = AW'(n_r - 1'b1);
        idx_nxt   = AW'(n_r - 1'b1);
        cur_v_nxt = '0;
        rev_nxt   = 1'b1;
        state_nxt = (n_r > CW'(1)) ? ST_SQ : ST_EMIT_INIT;
      end
      ST_SQ: begin
        sq_nxt    = vsq[2*REG_W-1:16];
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        lane_cmd.start = 1'b1;
        state_nxt      = ST_ACCW;
      end
      ST_ACCW: begin
        if (mrg.done) begin
          acc_nxt   = mrg.value;
          state_nxt = rev_r ? ST_MUL : ST_CAP;
        end
      end
      ST_CAP: begin
        lane_cmd.start  = 1'b1;
        lane_cmd.acc_op = 1'b0;
        lane_addr       = AW'(idx_r + 1'b1);
        state_nxt       = ST_CAPW;
      end
      ST_CAPW: begin
        lane_cmd.acc_op = 1'b0;
        if (mrg.done) begin
          cap_nxt   = mrg.value[REG_W-1:0];
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        phi_nxt   = step_r * amag[MAG_W-1:16];
        plo_nxt   = step_r * amag[15:0];
        state_nxt = ST_INC;
      end
      ST_INC: begin
        inc_nxt   = acc_r[ACC_W-1] ? -$signed({2'b00, imag}) : $signed({2'b00, imag});
        state_nxt = ST_ARG;
      end
      ST_ARG: begin
        sq_start  = 1'b1;
        state_nxt = ST_ROOT;
      end
      ST_ROOT: begin
        if (sq_done) begin
          cur_v_nxt = nv;
          if (!rev_r) begin
            fs_we     = 1'b1;
            fs_waddr  = AW'(idx_r + 1'b1);
            fs_wdata  = nv;
            idx_nxt   = AW'(idx_r + 1'b1);
            state_nxt = ((CW'(idx_r) + CW'(2)) < n_r) ? ST_SQ : ST_REV_INIT;
          end else begin
            rs_we     = 1'b1;
            rs_waddr  = AW'(idx_r - 1'b1);
            rs_wdata  = nv;
            idx_nxt   = AW'(idx_r - 1'b1);
            state_nxt = (idx_r > AW'(1)) ? ST_SQ : ST_EMIT_INIT;
          end
        end
      end
      ST_EMIT_INIT: begin
        idx_nxt   = '0;
        t_nxt     = '0;
        prev_nxt  = '0;
        state_nxt = ST_EMIT_RD;
      end
      ST_EMIT_RD: begin
        state_nxt = ST_EMIT_DAT;
      end
      ST_EMIT_DAT: begin
        v_nxt = rs_q;
        if (idx_r == '0) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = IDX_W'(idx_r);
          out_speed_nxt = rs_q;
          out_time_nxt  = t_r;
          out_last_nxt  = (CW'(idx_r) + CW'(1)) == n_r;
          state_nxt     = ST_EMIT_OUT;
        end else begin
          div_start = 1'b1;
          state_nxt = ST_EMIT_DIVW;
        end
      end
      ST_EMIT_DIVW: begin
        if (div_done) begin
          t_nxt         = tn;
          out_valid_nxt = 1'b1;
          out_idx_nxt   = IDX_W'(idx_r);
          out_speed_nxt = v_r;
          out_time_nxt  = tn;
          out_last_nxt  = (CW'(idx_r) + CW'(1)) == n_r;
          state_nxt     = ST_EMIT_OUT;
        end
      end
      ST_EMIT_OUT: begin
        if (out_tready) begin
          out_valid_nxt = 1'b0;
          prev_nxt      = v_r;
          if (out_last_r) begin
            count_nxt = '0;
            state_nxt = ST_LOAD;
          end else begin
            idx_nxt   = AW'(idx_r + 1'b1);
            state_nxt = ST_EMIT_RD;
          end
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    n_r         <= n_nxt;
    idx_r       <= idx_nxt;
    rev_r       <= rev_nxt;
    cur_v_r     <= cur_v_nxt;
    sq_r        <= sq_nxt;
    acc_r       <= acc_nxt;
    cap_r       <= cap_nxt;
    phi_r       <= phi_nxt;
    plo_r       <= plo_nxt;
    inc_r       <= inc_nxt;
    v_r         <= v_nxt;
    prev_r      <= prev_nxt;
    t_r         <= t_nxt;
    out_idx_r   <= out_idx_nxt;
    out_speed_r <= out_speed_nxt;
    out_time_r  <= out_time_nxt;
    out_last_r  <= out_last_nxt;
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  for (genvar j = 0; j < JOINTS; j++) begin : g_lane
    pvp_lane #(
      .MAX_POINTS (MAX_POINTS)
    ) u_lane (
      .clk         (clk),
      .rst_n       (rst_n),
      .wr_en       (lane_we),
      .wr_addr     (count_r[AW-1:0]),
      .wr_rate     (in_tdata[64*j +: DATA_W]),
      .wr_curv     (in_tdata[64*j+DATA_W +: DATA_W]),
      .vel_limit   (vel_lim_r[j]),
      .accel_limit (acc_lim_r[j]),
      .cmd         (lane_cmd),
      .rd_addr     (lane_addr),
      .res         (lane_res[j])
    );
  end

  pvp_merge #(
    .JOINTS (JOINTS)
  ) u_merge (
    .clk     (clk),
    .rst_n   (rst_n),
    .min_sel (min_sel),
    .res     (lane_res),
    .merged  (mrg)
  );

  pvp_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (sq_rad),
    .done     (sq_done),
    .root     (sq_root)
  );

  pvp_div u_tdiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .done     (div_done),
    .quotient (div_q)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'd0, out_time_r, out_speed_r, out_idx_r};
  assign out_tlast  = out_last_r;

  a_out_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (state_r == ST_EMIT_OUT))
    else $error("result shown outside the emit state");

  a_no_load_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_tvalid)
    else $error("input accepted while a result is pending");

  a_merge_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    mrg.done |-> (state_r == ST_ACCW || state_r == ST_CAPW))
    else $error("lane result arrived while not waiting for it");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |-> (count_r <= CW'(MAX_POINTS)))
    else $error("point count beyond store depth");

endmodule

// ===== rtl/pvp_div.sv =====
// Restoring divider, one quotient bit per cycle.
module pvp_div
  import pvp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIVN_W-1:0] dividend,
  input  logic [DIVD_W-1:0] divisor,
  output logic              done,
  output logic [DIVN_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIVN_W + 1);

  logic [DIVN_W-1:0] quo_r, quo_nxt;
  logic [DIVD_W-1:0] den_r, den_nxt;
  logic [DIVD_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;

  always_comb begin
    logic [DIVD_W:0] trial;
    logic            bit_q;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, quo_r[DIVN_W-1]};
    bit_q    = (trial >= {1'b0, den_r});
    if (start) begin
      quo_nxt  = dividend;
      den_nxt  = divisor;
      rem_nxt  = '0;
      cnt_nxt  = CNT_W'(DIVN_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quo_nxt = {quo_r[DIVN_W-2:0], bit_q};
      rem_nxt = bit_q ? DIVD_W'(trial - {1'b0, den_r}) : trial[DIVD_W-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== rtl/pvp_sqrt.sv =====
// Digit-by-digit integer square root, one root bit per cycle.
module pvp_sqrt
  import pvp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [RAD_W-1:0]  radicand,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  localparam int CNT_W = $clog2(ROOT_W + 1);
  localparam int REM_W = ROOT_W + 2;

  logic [RAD_W-1:0]  rad_r, rad_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [ROOT_W-1:0] root_r, root_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;

  always_comb begin
    logic [REM_W+1:0] rem2;
    logic [REM_W+1:0] trial;
    logic             bit_q;
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    rem2     = {rem_r, rad_r[RAD_W-1:RAD_W-2]};
    trial    = (REM_W+2)'({root_r, 2'b01});
    bit_q    = (rem2 >= trial);
    if (start) begin
      rad_nxt  = radicand;
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = CNT_W'(ROOT_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rad_nxt  = {rad_r[RAD_W-3:0], 2'b00};
      rem_nxt  = bit_q ? REM_W'(rem2 - trial) : rem2[REM_W-1:0];
      root_nxt = {root_r[ROOT_W-2:0], bit_q};
      cnt_nxt  = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    cnt_r  <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

// ===== rtl/pvp_lane.sv =====
// One joint lane: holds that joint's path derivatives and computes its speed cap
// or acceleration bound for one point.
module pvp_lane
  import pvp_pkg::*;
#(
  parameter int MAX_POINTS = PVP_MAX_POINTS
)
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [$clog2(MAX_POINTS)-1:0] wr_addr,
  input  logic [DATA_W-1:0]             wr_rate,
  input  logic [DATA_W-1:0]             wr_curv,
  input  logic [REG_W-1:0]              vel_limit,
  input  logic [REG_W-1:0]              accel_limit,
  input  lane_cmd_t                     cmd,
  input  logic [$clog2(MAX_POINTS)-1:0] rd_addr,
  output lane_res_t                     res
);

  logic [DATA_W-1:0] rate_mem [MAX_POINTS];
  logic [DATA_W-1:0] curv_mem [MAX_POINTS];
  logic [DATA_W-1:0] rate_q;
  logic [DATA_W-1:0] curv_q;

  lane_state_t             state_r, state_nxt;
  logic                    acc_op_r, acc_op_nxt;
  logic                    upper_r, upper_nxt;
  logic                    active_r, active_nxt;
  logic                    rneg_r, rneg_nxt;
  logic                    cneg_r, cneg_nxt;
  logic                    neg_r, neg_nxt;
  logic [DATA_W-1:0]       rmag_r, rmag_nxt;
  logic [61:0]             pm_hi_r, pm_hi_nxt;
  logic [47:0]             pm_lo_r, pm_lo_nxt;
  logic signed [ACC_W:0]   term_r, term_nxt;
  logic                    done_r, done_nxt;
  logic signed [ACC_W-1:0] val_r, val_nxt;

  logic              div_start;
  logic [DIVN_W-1:0] div_num;
  logic              div_done;
  logic [DIVN_W-1:0] div_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      rate_mem[wr_addr] <= wr_rate;
      curv_mem[wr_addr] <= wr_curv;
    end
    rate_q <= rate_mem[rd_addr];
    curv_q <= curv_mem[rd_addr];
  end

  always_comb begin
    logic [DATA_W-1:0]     cmag;
    logic [DIVN_W-1:0]     tm;
    logic [MAG_W-1:0]      tsat;
    logic signed [ACC_W:0] lim;
    logic signed [ACC_W:0] diff;
    logic signed [ACC_W:0] num;
    logic signed [ACC_W:0] wide_s;
    logic [MAG_W-1:0]      nmag;
    logic [MAG_W-1:0]      qsat;
    state_nxt  = state_r;
    acc_op_nxt = acc_op_r;
    upper_nxt  = upper_r;
    active_nxt = active_r;
    rneg_nxt   = rneg_r;
    cneg_nxt   = cneg_r;
    neg_nxt    = neg_r;
    rmag_nxt   = rmag_r;
    pm_hi_nxt  = pm_hi_r;
    pm_lo_nxt  = pm_lo_r;
    term_nxt   = term_r;
    done_nxt   = 1'b0;
    val_nxt    = val_r;
    div_start  = 1'b0;
    div_num    = '0;
    cmag       = mag32(curv_q);
    tm         = {1'b0, pm_hi_r} + DIVN_W'(pm_lo_r[47:16]);
    tsat       = (tm > DIVN_W'(WIDE_MAG)) ? WIDE_MAG : tm[MAG_W-1:0];
    wide_s     = $signed({2'b00, WIDE_MAG});
    lim        = upper_r ? $signed({18'd0, accel_limit}) : -$signed({18'd0, accel_limit});
    diff       = lim - term_r;
    if (diff > wide_s) begin
      num = wide_s;
    end else if (diff < -wide_s) begin
      num = -wide_s;
    end else begin
      num = diff;
    end
    nmag = num[ACC_W] ? MAG_W'(-num) : MAG_W'(num);
    qsat = (div_q > DIVN_W'(WIDE_MAG)) ? WIDE_MAG : div_q[MAG_W-1:0];
    case (state_r)
      LN_IDLE: begin
        if (cmd.start) begin
          acc_op_nxt = cmd.acc_op;
          upper_nxt  = cmd.upper;
          state_nxt  = LN_READ;
        end
      end
      LN_READ: begin
        active_nxt = (rate_q != '0);
        rneg_nxt   = rate_q[DATA_W-1];
        cneg_nxt   = curv_q[DATA_W-1];
        rmag_nxt   = mag32(rate_q);
        pm_hi_nxt  = cmag * cmd.sq[SQ_W-1:16];
        pm_lo_nxt  = cmag * cmd.sq[15:0];
        state_nxt  = LN_TERM;
      end
      LN_TERM: begin
        term_nxt  = cneg_r ? -$signed({2'b00, tsat}) : $signed({2'b00, tsat});
        state_nxt = LN_NUM;
      end
      LN_NUM: begin
        div_start = 1'b1;
        div_num   = acc_op_r ? {nmag, 16'd0} : {16'd0, vel_limit, 16'd0};
        neg_nxt   = num[ACC_W] ^ rneg_r;
        state_nxt = LN_DIV;
      end
      LN_DIV: begin
        if (div_done) begin
          done_nxt  = 1'b1;
          state_nxt = LN_IDLE;
          if (!active_r) begin
            val_nxt = acc_op_r ? (upper_r ? WIDE : -WIDE) : $signed({17'd0, VMAX});
          end else if (acc_op_r) begin
            val_nxt = neg_r ? -$signed({1'b0, qsat}) : $signed({1'b0, qsat});
          end else begin
            val_nxt = (div_q > DIVN_W'(VMAX)) ? $signed({17'd0, VMAX})
                                              : $signed({17'd0, div_q[REG_W-1:0]});
          end
        end
      end
      default: state_nxt = LN_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    acc_op_r <= acc_op_nxt;
    upper_r  <= upper_nxt;
    active_r <= active_nxt;
    rneg_r   <= rneg_nxt;
    cneg_r   <= cneg_nxt;
    neg_r    <= neg_nxt;
    rmag_r   <= rmag_nxt;
    pm_hi_r  <= pm_hi_nxt;
    pm_lo_r  <= pm_lo_nxt;
    term_r   <= term_nxt;
    val_r    <= val_nxt;
    if (!rst_n) begin
      state_r <= LN_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  pvp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (rmag_r),
    .done     (div_done),
    .quotient (div_q)
  );

  assign res.done  = done_r;
  assign res.value = val_r;

endmodule

// ===== rtl/pvp_merge.sv =====
// Merges the lane results into one minimum or maximum.
module pvp_merge
  import pvp_pkg::*;
#(
  parameter int JOINTS = PVP_JOINTS
)
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      min_sel,
  input  lane_res_t res [JOINTS],
  output lane_res_t merged
);

  logic                    valid_r, valid_nxt;
  logic signed [ACC_W-1:0] best_r, best_nxt;

  always_comb begin
    logic [JOINTS-1:0]       dn;
    logic signed [ACC_W-1:0] cand;
    best_nxt = $signed(res[0].value);
    for (int j = 0; j < JOINTS; j++) begin
      dn[j] = res[j].done;
      cand  = $signed(res[j].value);
      if (min_sel ? (cand < best_nxt) : (cand > best_nxt)) begin
        best_nxt = cand;
      end
    end
    // All lanes run the same schedule, so they finish together.
    valid_nxt = &dn;
  end

  always_ff @(posedge clk) begin
    best_r <= best_nxt;
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign merged.done  = valid_r;
  assign merged.value = best_r;

endmodule

// ===== bench/path_velocity_profile_top_tb.sv =====
// Self-checking testbench for the path velocity profile block.
`timescale 1ns / 1ps

module path_velocity_profile_top_tb
  import pvp_pkg::*;
();

  localparam int             NPTS      = 64;
  localparam int             NJ        = 3;
  localparam longint         ACC_SAT   = 64'h7FFF_FFFF_FFFF;
  localparam longint         ROOT_CAP  = 64'h3FFF_FFFF_FFFF;
  localparam longint         SPEED_SAT = 64'h7FFF_FFFF;
  localparam longint         TIME_SAT  = 64'hFFFF_FFFF;
  localparam logic [CFG_AW-1:0] REG_NONE = 3'd7;
  localparam int             CYCLE_LIMIT = 3000000;
  localparam int             SETTLE      = 40;
  localparam int             PHASE_ITEMS = 35;

  typedef struct {
    logic [IDX_W-1:0]  idx;
    logic [REG_W-1:0]  speed;
    logic [TIME_W-1:0] elapsed;
    logic              last;
  } profile_sample_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [IN_W-1:0]   in_tdata = '0;
  logic              in_tlast = 1'b0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_W-1:0]  out_tdata;
  logic              out_tlast;
  logic              cfg_wr_en = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [REG_W-1:0]  cfg_wdata = '0;

  path_velocity_profile_top uut (.*);

  // Predictor state
  logic [IN_W-1:0]    path_pts[NPTS];
  int                 path_len;
  longint unsigned    vel_lim[NJ];
  longint unsigned    acc_lim[NJ];
  longint unsigned    ds;
  longint unsigned    fwd_v[NPTS];
  longint unsigned    rev_v[NPTS];
  profile_sample_t    expected_profile[$];

  int  idle_pct = 0;
  int  stall_pct = 0;
  int  hold_left = 0;
  int  mismatches = 0;
  int  cycles = 0;
  int  items_sent = 0;
  int  paths_done = 0;
  int  results_seen = 0;

  initial forever #1 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver: random stalls plus an optional long hold-off.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // ---------------- fixed-point predictor ----------------
  function automatic longint unsigned qmul(longint unsigned a, longint unsigned b);
    return a * (b >> 16) + ((a * (b & 64'hFFFF)) >> 16);
  endfunction

  function automatic longint unsigned absval(longint v);
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  function automatic longint signed_sat(longint unsigned m, bit neg);
    if (m > ACC_SAT) m = ACC_SAT;
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint clamp_acc(longint v);
    if (v > ACC_SAT) return ACC_SAT;
    if (v < -ACC_SAT) return -ACC_SAT;
    return v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res = 0;
    longint unsigned b = 64'h4000_0000_0000_0000;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint joint_rate(int p, int j);
    return longint'($signed(path_pts[p][64*j +: 32]));
  endfunction

  function automatic longint joint_curv(int p, int j);
    return longint'($signed(path_pts[p][64*j+32 +: 32]));
  endfunction

  function automatic longint unsigned velocity_cap(int p);
    longint unsigned v = SPEED_SAT;
    longint unsigned q;
    for (int j = 0; j < NJ; j++) begin
      if (joint_rate(p, j) != 0) begin
        q = (vel_lim[j] << 16) / absval(joint_rate(p, j));
        if (q < v) v = q;
      end
    end
    return v;
  endfunction

  // Tightest acceleration (upper) or deceleration bound over the active joints.
  function automatic longint path_accel(int p, longint unsigned sv, bit upper);
    longint acc = upper ? ACC_SAT : -ACC_SAT;
    longint unsigned sq = qmul(sv, sv);
    longint r, c, term, lim, num, a;
    for (int j = 0; j < NJ; j++) begin
      r = joint_rate(p, j);
      c = joint_curv(p, j);
      if (r != 0) begin
        term = signed_sat(qmul(absval(c), sq), c < 0);
        lim = upper ? longint'(acc_lim[j]) : -longint'(acc_lim[j]);
        num = clamp_acc(lim - term);
        a = signed_sat((absval(num) << 16) / absval(r), (num < 0) != (r < 0));
        if (upper ? (a < acc) : (a > acc)) acc = a;
      end
    end
    return acc;
  endfunction

  function automatic longint unsigned reach_speed(longint unsigned v, longint sa);
    longint sq = longint'(qmul(v, v));
    longint inc = signed_sat(qmul(ds, absval(sa)) * 2, sa < 0);
    longint arg = sq + inc;
    if (arg < 0) arg = 0;
    if (arg > ROOT_CAP) arg = ROOT_CAP;
    return int_sqrt(longint'(arg) << 16);
  endfunction

  task automatic predict_profile();
    longint unsigned s, v, prev, t;
    profile_sample_t e;
    int n;
    n = path_len;
    prev = 0;
    t = 0;
    fwd_v[0] = 0;
    for (int i = 0; i + 1 < n; i++) begin
      s = reach_speed(fwd_v[i], path_accel(i, fwd_v[i], 1'b1));
      v = velocity_cap(i + 1);
      fwd_v[i+1] = (s < v) ? s : v;
    end
    rev_v[n-1] = 0;
    for (int i = n - 1; i > 0; i--) begin
      s = reach_speed(rev_v[i], path_accel(i - 1, rev_v[i], 1'b0));
      rev_v[i-1] = (s < fwd_v[i-1]) ? s : fwd_v[i-1];
    end
    for (int i = 0; i < n; i++) begin
      v = (fwd_v[i] < rev_v[i]) ? fwd_v[i] : rev_v[i];
      if (i > 0) begin
        t += (ds << 17) / (prev + v + 1);
        if (t > TIME_SAT) t = TIME_SAT;
      end
      prev = v;
      e.idx = i[IDX_W-1:0];
      e.speed = v[REG_W-1:0];
      e.elapsed = t[TIME_W-1:0];
      e.last = (i + 1 == n);
      expected_profile.insert(expected_profile.size(), e);
    end
    path_len = 0;
    paths_done++;
  endtask

  task automatic accept_point(logic [IN_W-1:0] d, logic last);
    if (path_len < NPTS) begin
      path_pts[path_len] = d;
      path_len++;
    end
    items_sent++;
    if (last) predict_profile();
  endtask

  function automatic void set_defaults();
    for (int j = 0; j < NJ; j++) begin
      vel_lim[j] = VEL_RST;
      acc_lim[j] = ACC_RST;
    end
    ds = STEP_RST;
    path_len = 0;
  endfunction

  // ---------------- result checker ----------------
  always @(posedge clk) begin
    profile_sample_t e;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (expected_profile.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result item: %h last %b", out_tdata, out_tlast);
      end else begin
        e = expected_profile.pop_front();
        if (out_tdata[5:0] !== e.idx || out_tdata[36:6] !== e.speed ||
            out_tdata[68:37] !== e.elapsed || out_tlast !== e.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"Mismatch: expected idx %0d speed %0d time %0d last %b, ",
                      "got idx %0d speed %0d time %0d last %b"},
                     e.idx, e.speed, e.elapsed, e.last, out_tdata[5:0], out_tdata[36:6],
                     out_tdata[68:37], out_tlast);
        end
      end
    end
  end

  // ---------------- drivers ----------------
  // Called at a falling edge; leaves valid high so back-to-back items need no gap.
  task automatic send_point(logic [IN_W-1:0] d, logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= d;
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    accept_point(d, last);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_AW-1:0] a, logic [REG_W-1:0] v);
    cfg_wr_en <= 1'b1;
    cfg_addr <= a;
    cfg_wdata <= v;
    if (a < REG_ACC_0) vel_lim[a] = v;
    else if (a < REG_STEP) acc_lim[a - REG_ACC_0] = v;
    else if (a == REG_STEP) ds = v;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    cfg_wr_en <= 1'b0;
    while (expected_profile.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(6))
      0: return 32'h0;
      1: return $urandom();
      2: return $urandom_range(32'h30000);
      3: return -$urandom_range(32'h30000);
      4: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      default: return $urandom_range(1) ? $urandom_range(32'h40_0000)
                                        : -$urandom_range(32'h40_0000);
    endcase
  endfunction

  function automatic logic [IN_W-1:0] rand_point();
    logic [IN_W-1:0] d;
    for (int k = 0; k < 6; k++) d[32*k +: 32] = rand_word();
    return d;
  endfunction

  function automatic logic [REG_W-1:0] rand_reg(bit is_step);
    case ($urandom_range(4))
      0: return is_step ? 31'd1 : 31'd0;
      1: return 31'h7FFF_FFFF;
      2: return REG_W'($urandom());
      default: return REG_W'($urandom_range(31'h4_0000, 31'h100));
    endcase
  endfunction

  task automatic send_path(int n);
    for (int i = 0; i < n; i++) send_point(rand_point(), i == n - 1);
  endtask

  task automatic random_config();
    for (int a = REG_VEL_0; a <= REG_STEP; a++)
      write_reg(a[CFG_AW-1:0], rand_reg(a == REG_STEP));
  endtask

  // ---------------- tests ----------------
  task automatic test_defaults();
    send_path(1);
    send_path(5);
    wait_idle();
  endtask

  task automatic test_field_extremes();
    send_point({6{32'h0}}, 1'b0);
    send_point({6{32'h7FFF_FFFF}}, 1'b0);
    send_point({6{32'h8000_0000}}, 1'b0);
    send_point({6{32'hFFFF_FFFF}}, 1'b0);
    send_point({32'h8000_0000, 32'h1, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                32'h1, 32'h8000_0000}, 1'b0);
    send_point({6{32'h0001_0000}}, 1'b1);
    wait_idle();
  endtask

  task automatic test_config_extremes();
    for (int a = REG_VEL_0; a <= REG_STEP; a++)
      write_reg(a[CFG_AW-1:0], 31'h7FFF_FFFF);
    write_reg(REG_NONE, 31'h5);
    wait_idle();
    send_path(4);
    wait_idle();
    for (int a = REG_VEL_0; a < REG_STEP; a++) write_reg(a[CFG_AW-1:0], 31'd0);
    write_reg(REG_STEP, 31'd1);
    wait_idle();
    send_path(4);
    wait_idle();
  endtask

  // More points than the store holds: the overflow is dropped, the final still runs.
  task automatic test_store_full();
    idle_pct = 10;
    send_path(NPTS + 3);
    wait_idle();
    idle_pct = 0;
  endtask

  task automatic test_random_phases();
    int n;
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = (ph == 1) ? 75 : (ph == 3) ? 38 : 0;
      stall_pct = (ph == 2) ? 75 : (ph == 3) ? 38 : 0;
      random_config();
      wait_idle();
      for (int k = 0; k < PHASE_ITEMS; k += n) begin
        n = ($urandom_range(9) == 0) ? $urandom_range(16, NPTS) : $urandom_range(1, 8);
        send_path(n);
      end
      wait_idle();
    end
    idle_pct = 0;
    stall_pct = 0;
  endtask

  // Long receiver hold-off while further paths are offered, so the input stalls.
  task automatic test_backpressure();
    hold_left = 4000;
    send_path(6);
    send_path(6);
    send_path(3);
    wait_idle();
  endtask

  initial begin
    set_defaults();
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_defaults();
    test_field_extremes();
    test_config_extremes();
    test_store_full();
    test_random_phases();
    test_backpressure();
    if (expected_profile.size() != 0) begin
      mismatches += expected_profile.size();
      $display("%0d expected result items never arrived", expected_profile.size());
    end
    $display("Sent %0d points in %0d paths under idle, stall and long hold-off phases.",
             items_sent, paths_done);
    $display("Checked %0d result items in %0d cycles, %0d mismatches.",
             results_seen, cycles, mismatches);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== path_velocity_profile_top.f =====
rtl/pvp_pkg.sv
rtl/pvp_div.sv
rtl/pvp_sqrt.sv
rtl/pvp_lane.sv
rtl/pvp_merge.sv
rtl/path_velocity_profile_top.sv
bench/path_velocity_profile_top_tb.sv
